[sv/mts_pkg.sv]
// Shared types and constants for the melody tone sequencer.
package mts_pkg;

  localparam int DIV_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Item kinds carried in tuser
  localparam logic [1:0] F_TICK  = 2'd0;
  localparam logic [1:0] F_START = 2'd1;
  localparam logic [1:0] F_STOP  = 2'd2;
  localparam logic [1:0] F_WRITE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] R_TEMPO = 2'd0;
  localparam logic [1:0] R_SONG_LEN = 2'd1;
  localparam logic [1:0] R_LOOP = 2'd2;

  localparam logic [DIV_W-1:0] C_REST_WHOLE = 32'd240000;
  localparam logic [DIV_W-1:0] C_PERIOD_NUM = 32'd2000000;
  localparam logic [DIV_W-1:0] C_CMP_DIV = 32'd5;
  localparam logic [DIV_W-1:0] C_GAP_DIV = 32'd10;
  localparam logic [15:0] C_REST_PERIOD = 16'd1000;
  localparam logic [7:0] C_TEMPO_RST = 8'd80;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

[sv/mts_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module mts_div import mts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     den;
  logic [DIV_W:0]       trial;
  logic                 fits;
  logic [DIV_W-1:0]     rem_next;

  // divisor of zero always fits, so the quotient comes out all ones
  assign trial    = {rem, quo[DIV_W-1]};
  assign fits     = trial >= {1'b0, den};
  assign rem_next = fits ? DIV_W'(trial - {1'b0, den}) : trial[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      den <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[sv/melody_tone_sequencer_top.sv]
// Melody tone sequencer: note table, playback control and PWM setting computation.
// One item at a time. Start, stop and idle ticks pass from idle to the done state and the result register.
// Table write: serial index reduction, then the table write.
// Tick that loads a note: serial index reduction, the table read and up to five
// back-to-back divisions in the shared divider.
// rst (synchronous) restores playback state and configuration registers; table contents stay undefined.
module melody_tone_sequencer_top import mts_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // entry_index[7:0], note_freq[23:8], note_duration[31:24]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // period_count[15:0], compare_count[31:16],
                                     // settings_update[32], playing[33], zero[39:34]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [8:0] DEPTH_9 = 9'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [2:0] DV_WHOLE = 3'd0;
  localparam logic [2:0] DV_PER   = 3'd1;
  localparam logic [2:0] DV_CMP   = 3'd2;
  localparam logic [2:0] DV_DUR   = 3'd3;
  localparam logic [2:0] DV_GAP   = 3'd4;

  logic [2:0]  state;
  logic [2:0]  step;
  logic [7:0]  tempo;
  logic [7:0]  song_len;
  logic        loop_en;
  logic [7:0]  note_position;
  logic [31:0] tick_count;
  logic [31:0] note_length;
  logic [31:0] gap_length;
  logic [31:0] whole;
  logic [15:0] cur_period;
  logic [15:0] cur_compare;
  logic        next_is_note;
  logic        running;
  logic        upd;
  logic        mod_wr;
  logic [2:0]  mod_cnt;
  logic [7:0]  mod_src;
  logic [7:0]  mod_rem;
  logic [8:0]  mod_trial;
  logic [7:0]  mod_rem_next;
  logic [15:0] cap_freq;
  logic [7:0]  cap_dur;
  logic [15:0] note_freq_r;
  logic [7:0]  note_code_r;
  logic [23:0] mem [TABLE_DEPTH];
  logic [23:0] rd_data;
  logic        acc;
  logic        out_free;
  logic        tick_hit;
  logic        pos_wrap;
  logic [7:0]  pos_eff;
  logic [15:0] rd_freq;
  logic [31:0] freq240;
  logic [8:0]  code_mag;
  logic        dotted;
  logic [31:0] div_q;
  logic [31:0] dur_adj;
  logic [31:0] dur3;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  mts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign tick_hit      = (tick_count == note_length) || (tick_count == gap_length);
  assign pos_wrap      = note_position >= song_len;
  assign pos_eff       = pos_wrap ? 8'd0 : note_position;

  // index reduction modulo the table depth, one bit per cycle
  assign mod_trial    = {mod_rem, mod_src[7]};
  assign mod_rem_next = (mod_trial >= DEPTH_9) ? 8'(mod_trial - DEPTH_9) : mod_trial[7:0];

  // 240 * f as (f << 8) - (f << 4); never exceeds 24 bits
  assign rd_freq  = rd_data[15:0];
  assign freq240  = ({16'd0, rd_freq} << 8) - ({16'd0, rd_freq} << 4);
  assign code_mag = note_code_r[7] ? (9'd0 - {1'b1, note_code_r}) : {1'b0, note_code_r};
  assign dotted   = note_code_r[7] || (note_code_r == 8'd0);
  assign div_q    = div_rsp.quotient;
  assign dur_adj  = dotted ? (div_q + (div_q >> 1)) : div_q;
  assign dur3     = {dur_adj[30:0], 1'b0} + dur_adj;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = whole;
    div_req.divisor  = {23'd0, code_mag};
    if (state == S_LOAD) begin
      div_req.start    = 1'b1;
      div_req.dividend = (rd_freq == 16'd0) ? C_REST_WHOLE : freq240;
      div_req.divisor  = {24'd0, tempo};
    end else if (state == S_DIV && div_rsp.done) begin
      unique case (step)
        DV_WHOLE: begin
          div_req.start = 1'b1;
          if (note_freq_r == 16'd0) begin
            div_req.dividend = div_q;
            div_req.divisor  = {23'd0, code_mag};
          end else begin
            div_req.dividend = C_PERIOD_NUM;
            div_req.divisor  = {16'd0, note_freq_r};
          end
        end
        DV_PER: begin
          div_req.start    = 1'b1;
          div_req.dividend = {16'd0, div_q[15:0]};
          div_req.divisor  = C_CMP_DIV;
        end
        DV_CMP: begin
          div_req.start    = 1'b1;
          div_req.dividend = whole;
          div_req.divisor  = {23'd0, code_mag};
        end
        DV_DUR: begin
          div_req.start    = 1'b1;
          div_req.dividend = dur3;
          div_req.divisor  = C_GAP_DIV;
        end
        default: div_req.start = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tempo    <= C_TEMPO_RST;
      song_len <= 8'd0;
      loop_en  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        R_TEMPO:    tempo    <= cfg_data;
        R_SONG_LEN: song_len <= cfg_data;
        R_LOOP:     loop_en  <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= DV_WHOLE;
      note_position <= 8'd0;
      tick_count    <= 32'd0;
      note_length   <= 32'd0;
      gap_length    <= 32'd0;
      cur_period    <= C_REST_PERIOD;
      cur_compare   <= C_REST_PERIOD;
      next_is_note  <= 1'b1;
      running       <= 1'b0;
      upd           <= 1'b0;
      mod_wr        <= 1'b0;
      mod_cnt       <= 3'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            unique case (s_axis_tuser)
              F_TICK: begin
                if (!running) begin
                  upd   <= 1'b0;
                  state <= S_DONE;
                end else if (!tick_hit) begin
                  tick_count <= tick_count + 32'd1;
                  upd        <= 1'b0;
                  state      <= S_DONE;
                end else if (!next_is_note) begin
                  // gap phase: silence
                  tick_count   <= 32'd0;
                  cur_compare  <= cur_period;
                  next_is_note <= 1'b1;
                  upd          <= 1'b1;
                  state        <= S_DONE;
                end else if (pos_wrap && !loop_en) begin
                  tick_count <= 32'd0;
                  running    <= 1'b0;
                  upd        <= 1'b0;
                  state      <= S_DONE;
                end else begin
                  tick_count    <= 32'd0;
                  note_position <= pos_eff;
                  mod_cnt       <= 3'd0;
                  mod_wr        <= 1'b0;
                  upd           <= 1'b0;
                  state         <= S_MOD;
                end
              end
              F_START: begin
                note_position <= 8'd0;
                tick_count    <= 32'd0;
                note_length   <= 32'd0;
                gap_length    <= 32'd0;
                next_is_note  <= 1'b1;
                running       <= 1'b1;
                upd           <= 1'b0;
                state         <= S_DONE;
              end
              F_STOP: begin
                running     <= 1'b0;
                cur_compare <= cur_period;
                upd         <= 1'b1;
                state       <= S_DONE;
              end
              F_WRITE: begin
                mod_cnt <= 3'd0;
                mod_wr  <= 1'b1;
                upd     <= 1'b0;
                state   <= S_MOD;
              end
              default: begin
                upd   <= 1'b0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MOD: begin
          mod_cnt <= mod_cnt + 3'd1;
          if (mod_cnt == 3'd7) begin
            state <= mod_wr ? S_WR : S_RD;
          end
        end
        S_WR: state <= S_DONE;
        S_RD: state <= S_LOAD;
        S_LOAD: begin
          step  <= DV_WHOLE;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            unique case (step)
              DV_WHOLE: begin
                if (note_freq_r == 16'd0) begin
                  cur_period  <= C_REST_PERIOD;
                  cur_compare <= C_REST_PERIOD;
                  step        <= DV_DUR;
                end else begin
                  step <= DV_PER;
                end
              end
              DV_PER: begin
                cur_period <= div_q[15:0];
                step       <= DV_CMP;
              end
              DV_CMP: begin
                cur_compare <= div_q[15:0];
                step        <= DV_DUR;
              end
              DV_DUR: begin
                note_length <= dur_adj;
                step        <= DV_GAP;
              end
              DV_GAP: begin
                gap_length    <= div_q;
                next_is_note  <= 1'b0;
                note_position <= note_position + 8'd1;
                upd           <= 1'b1;
                state         <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cap_freq <= s_axis_tdata[23:8];
      cap_dur  <= s_axis_tdata[31:24];
      mod_src  <= (s_axis_tuser == F_WRITE) ? s_axis_tdata[7:0] : pos_eff;
      mod_rem  <= 8'd0;
    end else if (state == S_MOD) begin
      mod_src <= {mod_src[6:0], 1'b0};
      mod_rem <= mod_rem_next;
    end
    if (state == S_LOAD) begin
      note_freq_r <= rd_freq;
      note_code_r <= rd_data[23:16];
    end
    if (state == S_DIV && div_rsp.done && step == DV_WHOLE) begin
      whole <= div_q;
    end
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= {6'd0, running, upd, cur_compare, cur_period};
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WR) begin
      mem[mod_rem[IDX_W-1:0]] <= {cap_dur, cap_freq};
    end
    rd_data <= mem[mod_rem[IDX_W-1:0]];
  end

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (state == S_IDLE) && !m_axis_tvalid)
    else $error("not idle after reset");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside the division sequence");

  a_div_while_running: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> running)
    else $error("note load while playback stopped");

  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_rsp.busy)
    else $error("item accepted while divider busy");

endmodule
